### sv/tds_pkg.sv
package tds_pkg;

	localparam int TIMER_SLOTS_DEF = 16;
	localparam logic [31:0] ROLLOVER_WINDOW_RST = 32'd3600000;

	localparam logic [2:0] REQ_ADD = 3'd0;
	localparam logic [2:0] REQ_CANCEL = 3'd1;
	localparam logic [2:0] REQ_REFRESH = 3'd2;
	localparam logic [2:0] REQ_RESET = 3'd3;
	localparam logic [2:0] REQ_QUERY = 3'd4;
	localparam logic [2:0] REQ_EXPIRE = 3'd5;

	localparam logic [1:0] STS_OK = 2'd0;
	localparam logic [1:0] STS_INACTIVE = 2'd1;
	localparam logic [1:0] STS_FULL = 2'd2;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [3:0]  slot;
		logic [31:0] period_ms;
		logic        recurring;
		logic        anchor_now;
		logic [63:0] now_ms;
	} tds_in_t;

	typedef struct packed {
		logic        kind;
		logic [1:0]  status;
		logic [3:0]  slot_out;
		logic [63:0] wait_ms;
		logic        became_earliest;
		logic        any_active;
		logic        last;
	} tds_out_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ADD,
		OP_CANCEL,
		OP_REFRESH,
		OP_RESET,
		OP_CAPTURE,
		OP_EXPIRE
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic [63:0] now;
		logic [31:0] period;
		logic        rec;
		logic        anchor_now;
		logic        roll;
	} cell_cmd_t;

	typedef struct packed {
		logic active;
		logic rec;
		logic due;
		logic same_period;
	} cell_sts_t;

endpackage

### sv/tds_cell.sv
module tds_cell import tds_pkg::*; #(
	parameter int SW = 4,
	parameter logic [SW-1:0] IDX = '0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          sel,
	input  cell_cmd_t     cmd,
	input  logic          use_cand,
	input  logic          cin_found,
	input  logic [63:0]   cin_dl,
	input  logic [SW-1:0] cin_slot,
	output logic          cout_found,
	output logic [63:0]   cout_dl,
	output logic [SW-1:0] cout_slot,
	output cell_sts_t     sts
);

	logic        active_q, rec_q, cand_q;
	logic [31:0] period_q;
	logic [63:0] dl_q;
	logic [63:0] base, sum;
	logic [31:0] addend;
	logic        elig, take;

	always_comb begin
		base = cmd.now;
		if (cmd.op == OP_RESET && !cmd.anchor_now) begin
			base = dl_q - {32'b0, period_q};
		end
		addend = (cmd.op == OP_ADD || cmd.op == OP_RESET) ? cmd.period : period_q;
		sum = base + {32'b0, addend};
	end

	assign sts.active = active_q;
	assign sts.rec = rec_q;
	assign sts.due = active_q && (cmd.roll || dl_q <= cmd.now);
	assign sts.same_period = (period_q == cmd.period);

	// pass on the better of the incoming best and this slot
	assign elig = use_cand ? cand_q : active_q;
	assign take = elig && (!cin_found || dl_q < cin_dl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			rec_q <= 1'b0;
			cand_q <= 1'b0;
			cout_found <= 1'b0;
		end else begin
			cout_found <= take || cin_found;
			if (sel) begin
				unique case (cmd.op)
					OP_ADD: begin
						active_q <= 1'b1;
						rec_q <= cmd.rec;
					end
					OP_CANCEL: active_q <= 1'b0;
					OP_CAPTURE: cand_q <= sts.due;
					OP_EXPIRE: begin
						cand_q <= 1'b0;
						if (!rec_q) begin
							active_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		cout_dl <= take ? dl_q : cin_dl;
		cout_slot <= take ? IDX : cin_slot;
		if (sel) begin
			unique case (cmd.op)
				OP_ADD, OP_RESET: begin
					period_q <= cmd.period;
					dl_q <= sum;
				end
				OP_REFRESH: dl_q <= sum;
				OP_EXPIRE: begin
					if (rec_q) begin
						dl_q <= sum;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

### sv/timer_deadline_scheduler.sv
// Add (with a free slot), reset (with a new period or anchor_now) and query
//   search the slot chain for the earliest deadline before their result; the
//   other requests reply directly. An expiry check gives one report per due
//   slot, each after a new search; the search ripples one cell per cycle
//   down the slot chain.
// One request at a time; busy stays high until its last result beat.
// Reset: asynchronous, active low; all slots free, no wake-up pending.
module timer_deadline_scheduler import tds_pkg::*; #(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  tds_in_t     req,
	output logic        result_valid,
	output tds_out_t    result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = $clog2(TIMER_SLOTS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_REPLY, ST_SCAN, ST_XSCAN} state_t;

	state_t       state_q;
	logic [CW-1:0] cnt_q, remain_q;
	logic [2:0]   op_q;
	logic [SW-1:0] tgt_q;
	logic [63:0]  now_q, prev_q;
	logic         pending_q, final_act_q;
	logic [31:0]  window_q;
	tds_out_t     res_q;
	logic         res_valid_q;

	cell_cmd_t    cmd;
	logic [TIMER_SLOTS-1:0] sel;
	cell_sts_t    sts [TIMER_SLOTS];
	logic         cf [TIMER_SLOTS];
	logic [63:0]  cd [TIMER_SLOTS];
	logic [SW-1:0] cs [TIMER_SLOTS];

	logic [TIMER_SLOTS-1:0] act_v, due_v, keep_v;
	logic [SW-1:0] free_idx, sidx;
	logic          full, slot_ok, roll, scan_done;
	logic [CW-1:0] due_cnt;

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign result = res_q;
	assign result_valid = res_valid_q;

	// flatten cell status for the controller
	always_comb begin
		for (int i = 0; i < TIMER_SLOTS; i++) begin
			act_v[i] = sts[i].active;
			due_v[i] = sts[i].due;
			keep_v[i] = sts[i].active && !(sts[i].due && !sts[i].rec);
		end
		free_idx = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!act_v[i]) begin
				free_idx = SW'(i);
			end
		end
	end

	assign full = &act_v;
	assign due_cnt = CW'($countones(due_v));
	assign sidx = SW'(req.slot);
	assign slot_ok = (32'(req.slot) < TIMER_SLOTS) && act_v[sidx];
	// backward jump past the window; the subtraction wraps at 2^64
	assign roll = (req.now_ms < prev_q) && (req.now_ms < prev_q - {32'b0, window_q});
	assign scan_done = (cnt_q == CW'(TIMER_SLOTS));

	// drive the slot command from the request in idle, else from the latched time
	always_comb begin
		cmd.op = OP_NONE;
		cmd.now = (state_q == ST_IDLE) ? req.now_ms : now_q;
		cmd.period = req.period_ms;
		cmd.rec = req.recurring;
		cmd.anchor_now = req.anchor_now;
		cmd.roll = roll;
		sel = '0;
		if (state_q == ST_IDLE && start) begin
			unique case (req.req_type)
				REQ_ADD: begin
					if (!full) begin
						cmd.op = OP_ADD;
						sel[free_idx] = 1'b1;
					end
				end
				REQ_CANCEL: begin
					if (slot_ok) begin
						cmd.op = OP_CANCEL;
						sel[sidx] = 1'b1;
					end
				end
				REQ_REFRESH: begin
					if (slot_ok) begin
						cmd.op = OP_REFRESH;
						sel[sidx] = 1'b1;
					end
				end
				REQ_RESET: begin
					if (slot_ok && (!sts[sidx].same_period || req.anchor_now)) begin
						cmd.op = OP_RESET;
						sel[sidx] = 1'b1;
					end
				end
				REQ_EXPIRE: begin
					cmd.op = OP_CAPTURE;
					sel = '1;
				end
				default: ;
			endcase
		end else if (state_q == ST_XSCAN && scan_done) begin
			cmd.op = OP_EXPIRE;
			sel[cs[TIMER_SLOTS-1]] = 1'b1;
		end
	end

	// slot chain: each cell hands its running earliest to the next one
	for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
		tds_cell #(.SW(SW), .IDX(SW'(i))) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.sel       (sel[i]),
			.cmd       (cmd),
			.use_cand  (state_q == ST_XSCAN),
			.cin_found ((i == 0) ? 1'b0 : cf[(i == 0) ? 0 : i-1]),
			.cin_dl    ((i == 0) ? 64'd0 : cd[(i == 0) ? 0 : i-1]),
			.cin_slot  ((i == 0) ? {SW{1'b0}} : cs[(i == 0) ? 0 : i-1]),
			.cout_found(cf[i]),
			.cout_dl   (cd[i]),
			.cout_slot (cs[i]),
			.sts       (sts[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			remain_q <= '0;
			op_q <= REQ_ADD;
			tgt_q <= '0;
			now_q <= '0;
			prev_q <= '0;
			pending_q <= 1'b0;
			final_act_q <= 1'b0;
			window_q <= ROLLOVER_WINDOW_RST;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				window_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q <= req.req_type;
						now_q <= req.now_ms;
						cnt_q <= '0;
						res_q <= '0;
						res_q.last <= 1'b1;
						state_q <= ST_REPLY;
						unique case (req.req_type)
							REQ_ADD: begin
								if (full) begin
									res_q.status <= STS_FULL;
								end else begin
									tgt_q <= free_idx;
									res_q.slot_out <= 4'(free_idx);
									state_q <= ST_SCAN;
								end
							end
							REQ_CANCEL, REQ_REFRESH: begin
								if (!slot_ok) begin
									res_q.status <= STS_INACTIVE;
								end
							end
							REQ_RESET: begin
								if (!slot_ok) begin
									res_q.status <= STS_INACTIVE;
								end else if (!sts[sidx].same_period || req.anchor_now) begin
									tgt_q <= sidx;
									state_q <= ST_SCAN;
								end
							end
							REQ_QUERY: state_q <= ST_SCAN;
							REQ_EXPIRE: begin
								if (|act_v) begin
									prev_q <= req.now_ms;
									if (due_cnt != '0) begin
										remain_q <= due_cnt;
										final_act_q <= |keep_v;
										state_q <= ST_XSCAN;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_REPLY: begin
					res_q.any_active <= |act_v;
					res_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (scan_done) begin
						res_q.any_active <= |act_v;
						res_valid_q <= 1'b1;
						state_q <= ST_IDLE;
						if (op_q == REQ_QUERY) begin
							// clear the wake-up mark and report time to the first deadline
							pending_q <= 1'b0;
							if (!cf[TIMER_SLOTS-1]) begin
								res_q.wait_ms <= '1;
							end else if (now_q >= cd[TIMER_SLOTS-1]) begin
								res_q.wait_ms <= '0;
							end else begin
								res_q.wait_ms <= cd[TIMER_SLOTS-1] - now_q;
							end
						end else if (cf[TIMER_SLOTS-1] && cs[TIMER_SLOTS-1] == tgt_q
								&& !pending_q) begin
							pending_q <= 1'b1;
							res_q.became_earliest <= 1'b1;
						end
					end
				end
				ST_XSCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (scan_done) begin
						// report the earliest due slot, then search again without it
						res_q <= '0;
						res_q.kind <= 1'b1;
						res_q.slot_out <= 4'(cs[TIMER_SLOTS-1]);
						res_q.any_active <= final_act_q;
						res_q.last <= (remain_q == CW'(1));
						res_valid_q <= 1'b1;
						remain_q <= remain_q - 1'b1;
						cnt_q <= '0;
						if (remain_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sv/tds_chk.sv
module tds_chk import tds_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     result_valid,
	input tds_out_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted request");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> busy)
		else $error("block idle while expiry reports remain");

	a_report_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind |-> result.status == STS_OK && result.wait_ms == 64'd0
			&& !result.became_earliest)
		else $error("malformed expiry report");

	a_early_active: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.became_earliest |-> result.any_active)
		else $error("earliest flag with no active slot");

endmodule

bind timer_deadline_scheduler tds_chk u_tds_chk (.*);

### tb/tds_checker.sv
`timescale 1ns / 100ps

module tds_checker import tds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  tds_in_t     req,
	input  logic        result_valid,
	input  tds_out_t    result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          reports
);

	localparam int NSLOT = TIMER_SLOTS_DEF;

	bit          t_active [NSLOT];
	bit          t_rec [NSLOT];
	logic [31:0] t_period [NSLOT];
	logic [63:0] t_deadline [NSLOT];
	logic [63:0] prev_time;
	bit          wake_pend;
	logic [31:0] window_ms;
	tds_out_t    due_q [$];

	function automatic bit ahead(int a, int b);
		if (t_deadline[a] != t_deadline[b]) begin
			return t_deadline[a] < t_deadline[b];
		end
		return a < b;
	endfunction

	function automatic int earliest_slot();
		int best;
		best = -1;
		for (int i = 0; i < NSLOT; i++) begin
			if (t_active[i] && (best < 0 || ahead(i, best))) begin
				best = i;
			end
		end
		return best;
	endfunction

	function automatic bit any_on();
		for (int i = 0; i < NSLOT; i++) begin
			if (t_active[i]) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// raise the pending mark when slot k is now at the front
	function automatic bit claim_front(int k);
		if (earliest_slot() == k && !wake_pend) begin
			wake_pend = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic predict_timers(input tds_in_t r);
		tds_out_t    o;
		bit          ok;
		bit          roll;
		bit          due [NSLOT];
		int          order [$];
		int          k;
		int          b;
		logic [63:0] base;
		o = '0;
		ok = t_active[r.slot];
		case (r.req_type)
			REQ_ADD: begin
				k = -1;
				for (int i = 0; i < NSLOT && k < 0; i++) begin
					if (!t_active[i]) begin
						k = i;
					end
				end
				if (k < 0) begin
					o.status = STS_FULL;
				end else begin
					t_active[k] = 1'b1;
					t_rec[k] = r.recurring;
					t_period[k] = r.period_ms;
					t_deadline[k] = r.now_ms + 64'(r.period_ms);
					o.slot_out = 4'(k);
					o.became_earliest = claim_front(k);
				end
			end
			REQ_CANCEL: begin
				if (ok) begin
					t_active[r.slot] = 1'b0;
				end else begin
					o.status = STS_INACTIVE;
				end
			end
			REQ_REFRESH: begin
				if (ok) begin
					t_deadline[r.slot] = r.now_ms + 64'(t_period[r.slot]);
				end else begin
					o.status = STS_INACTIVE;
				end
			end
			REQ_RESET: begin
				if (!ok) begin
					o.status = STS_INACTIVE;
				end else if (r.period_ms != t_period[r.slot] || r.anchor_now) begin
					base = r.anchor_now ? r.now_ms
						: t_deadline[r.slot] - 64'(t_period[r.slot]);
					t_period[r.slot] = r.period_ms;
					t_deadline[r.slot] = base + 64'(r.period_ms);
					o.became_earliest = claim_front(int'(r.slot));
				end
			end
			REQ_QUERY: begin
				k = earliest_slot();
				wake_pend = 1'b0;
				if (k < 0) begin
					o.wait_ms = '1;
				end else if (r.now_ms < t_deadline[k]) begin
					o.wait_ms = t_deadline[k] - r.now_ms;
				end
			end
			REQ_EXPIRE: begin
				if (any_on()) begin
					roll = r.now_ms < prev_time &&
						r.now_ms < prev_time - 64'(window_ms);
					prev_time = r.now_ms;
					for (int i = 0; i < NSLOT; i++) begin
						due[i] = t_active[i] && (roll || t_deadline[i] <= r.now_ms);
					end
					// pull due slots out in (deadline, slot) order
					forever begin
						b = -1;
						for (int i = 0; i < NSLOT; i++) begin
							if (due[i] && (b < 0 || ahead(i, b))) begin
								b = i;
							end
						end
						if (b < 0) begin
							break;
						end
						due[b] = 1'b0;
						order.insert(order.size(), b);
					end
					foreach (order[j]) begin
						if (t_rec[order[j]]) begin
							t_deadline[order[j]] = r.now_ms + 64'(t_period[order[j]]);
						end else begin
							t_active[order[j]] = 1'b0;
						end
					end
					foreach (order[j]) begin
						o = '0;
						o.kind = 1'b1;
						o.slot_out = 4'(order[j]);
						o.any_active = any_on();
						o.last = (j == order.size() - 1);
						due_q.insert(due_q.size(), o);
					end
					if (order.size() > 0) begin
						return;
					end
				end
			end
			default: begin
			end
		endcase
		o.any_active = any_on();
		o.last = 1'b1;
		due_q.insert(due_q.size(), o);
	endtask

	function automatic int field_diff(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: mismatch in %s: expected %h, actual %h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tds_out_t e;
		int bad;
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++) begin
				t_active[i] = 1'b0;
				t_rec[i] = 1'b0;
				t_period[i] = '0;
				t_deadline[i] = '0;
			end
			prev_time = '0;
			wake_pend = 1'b0;
			window_ms = ROLLOVER_WINDOW_RST;
			due_q.delete();
			errors = 0;
			reports = 0;
			pending = 0;
		end else begin
			// check a result beat against the oldest expectation
			if (result_valid) begin
				if (due_q.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, result);
					errors++;
				end else begin
					e = due_q.pop_front();
					bad = 0;
					bad += field_diff("kind", 64'(e.kind), 64'(result.kind));
					bad += field_diff("status", 64'(e.status), 64'(result.status));
					bad += field_diff("slot_out", 64'(e.slot_out), 64'(result.slot_out));
					bad += field_diff("wait_ms", e.wait_ms, result.wait_ms);
					bad += field_diff("became_earliest", 64'(e.became_earliest),
						64'(result.became_earliest));
					bad += field_diff("any_active", 64'(e.any_active),
						64'(result.any_active));
					bad += field_diff("last", 64'(e.last), 64'(result.last));
					if (bad != 0) begin
						errors++;
					end
					if (e.kind) begin
						reports++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				window_ms = cfg_data;
			end
			if (start && !busy) begin
				predict_timers(req);
			end
			pending = due_q.size();
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb import tds_pkg::*; ();

	localparam int LIMIT = 400000;
	localparam int RANDOM_ITEMS = 144;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	tds_in_t     req = '0;
	logic        result_valid;
	tds_out_t    result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	int          errors;
	int          pending;
	int          reports;
	int          cycles = 0;
	int          sent = 0;
	bit          no_idle = 1'b0;
	// running wall clock handed to the block with every random request
	logic [63:0] clock_ms = 64'd1000;

	always #1 clk = ~clk;

	timer_deadline_scheduler uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.result_valid(result_valid), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	tds_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.result_valid(result_valid), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .reports(reports)
	);

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Hand one request beat to the block. Always wait on the clock first
	// so start is never lowered and raised in the same step; add a random idle
	// gap about a third of the time unless in a burst stretch.
	task automatic issue(input tds_in_t r);
		int gap;
		gap = 0;
		if (!no_idle && $urandom_range(0, 99) < 33) begin
			gap = $urandom_range(1, 6);
		end
		repeat (gap + 1) @(posedge clk);
		req <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		start <= 1'b0;
		sent++;
	endtask

	task automatic plain(input logic [2:0] op, input int s, input logic [31:0] per,
		input bit rec, input bit fn, input logic [63:0] now);
		tds_in_t r;
		r.req_type = op;
		r.slot = 4'(s);
		r.period_ms = per;
		r.recurring = rec;
		r.anchor_now = fn;
		r.now_ms = now;
		issue(r);
	endtask

	// Drain: every expected beat in, then let an in-flight request settle.
	task automatic settle();
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_window(input logic [31:0] w);
		settle();
		cfg_data <= w;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_period();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) begin
			return 32'(10 * $urandom_range(1, 3));
		end else if (p < 90) begin
			return 32'($urandom_range(0, 120));
		end else if (p < 95) begin
			return '1;
		end
		return $urandom();
	endfunction

	// Move the clock: mostly forward a little, sometimes back (small or
	// past the rollover window), rarely to an arbitrary 64-bit value.
	function automatic logic [63:0] tick();
		int p;
		p = $urandom_range(0, 99);
		if (p < 85) begin
			clock_ms = clock_ms + 64'($urandom_range(0, 60));
		end else if (p < 91) begin
			clock_ms = clock_ms - 64'($urandom_range(1, 200));
		end else if (p < 96) begin
			clock_ms = clock_ms - 64'($urandom()) - 64'($urandom_range(0, 4000000));
		end else begin
			clock_ms = {$urandom(), $urandom()};
		end
		return clock_ms;
	endfunction

	task automatic random_phase(input int n);
		tds_in_t r;
		int p;
		for (int i = 0; i < n; i++) begin
			no_idle = (i >= n / 3 && i < n / 3 + n / 4);
			p = $urandom_range(0, 99);
			r.slot = 4'($urandom_range(0, 15));
			r.period_ms = pick_period();
			r.recurring = 1'($urandom_range(0, 1));
			r.anchor_now = 1'($urandom_range(0, 1));
			r.now_ms = tick();
			if (p < 25) begin
				r.req_type = REQ_ADD;
			end else if (p < 35) begin
				r.req_type = REQ_CANCEL;
			end else if (p < 45) begin
				r.req_type = REQ_REFRESH;
			end else if (p < 57) begin
				r.req_type = REQ_RESET;
			end else if (p < 70) begin
				r.req_type = REQ_QUERY;
			end else if (p < 96) begin
				r.req_type = REQ_EXPIRE;
			end else begin
				r.req_type = 3'($urandom_range(6, 7));
			end
			issue(r);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-table expiry and query, fill to full, then each
		// slot operation, unchanged reset, rollover and an unknown request.
		plain(REQ_EXPIRE, 0, 0, 0, 0, 64'd1000);
		plain(REQ_QUERY, 0, 0, 0, 0, 64'd1000);
		for (int i = 0; i < 16; i++) begin
			plain(REQ_ADD, 0, (i == 15) ? 32'hFFFF_FFFF : 32'(100 - 5 * i),
				1'(i % 2), 0, 64'd1000);
		end
		plain(REQ_ADD, 0, 32'd7, 1, 0, 64'd1000);
		plain(REQ_CANCEL, 3, 0, 0, 0, 64'd1001);
		plain(REQ_CANCEL, 3, 0, 0, 0, 64'd1002);
		plain(REQ_REFRESH, 5, 0, 0, 0, 64'd1003);
		plain(REQ_RESET, 6, 32'd70, 0, 0, 64'd1004);
		plain(REQ_RESET, 7, 32'd1, 0, 1, 64'd1005);
		plain(REQ_QUERY, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
		plain(REQ_EXPIRE, 0, 0, 0, 0, 64'd1070);
		plain(REQ_EXPIRE, 0, 0, 0, 0, 64'd5);
		plain(3'd7, 15, 32'hFFFF_FFFF, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF);

		random_phase(RANDOM_ITEMS / 4);
		set_window(32'd0);
		random_phase(RANDOM_ITEMS / 4);
		set_window(32'hFFFF_FFFF);
		random_phase(RANDOM_ITEMS / 4);
		set_window($urandom_range(50, 500));
		random_phase(RANDOM_ITEMS / 4);

		settle();
		$display("%0d requests sent across four rollover window settings;", sent);
		$display("%0d expiry reports checked", reports);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
